### hw/rtl/w3sf_pkg.sv
`default_nettype none

package w3sf_pkg;

   localparam int PIXEL_W     = 8;
   localparam int WEIGHT_BITS = 4;
   localparam int TAPS        = 9;
   localparam int OUT_POS_W   = 10;

   localparam int PROD_W   = PIXEL_W + WEIGHT_BITS;
   localparam int WEIGHT_MAX = (2 ** WEIGHT_BITS) - 1;
   localparam int PIXEL_MAX  = (2 ** PIXEL_W) - 1;
   localparam int WSUM_W   = $clog2(TAPS * WEIGHT_MAX + 1);
   localparam int ROWSUM_W = $clog2(3 * WEIGHT_MAX * PIXEL_MAX + 1);
   localparam int ACC_W    = $clog2(TAPS * WEIGHT_MAX * PIXEL_MAX + 1);

   localparam int CFG_SIZE_W  = 11;
   localparam int KERNEL_W    = TAPS * WEIGHT_BITS;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_INDEX_W = 2;

   localparam logic [REG_INDEX_W-1:0] REG_WIDTH   = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_HEIGHT  = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_WEIGHTS = 2'd2;

   localparam logic [CFG_SIZE_W-1:0] MIN_SIZE      = 11'd3;
   localparam logic [CFG_SIZE_W-1:0] DEFAULT_SIZE  = 11'd512;
   localparam logic [KERNEL_W-1:0]   DEFAULT_KERNEL = 36'h141454141;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [TAPS-1:0] window_type;

   typedef struct packed {
      logic                 interior;
      logic                 last;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] column;
   } position_type;

endpackage

`default_nettype wire

### hw/rtl/w3sf_ram.sv
`default_nettype none

module w3sf_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/w3sf_csr.sv
`default_nettype none

module w3sf_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [w3sf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [w3sf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [w3sf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output logic      [w3sf_pkg::CFG_SIZE_W-1:0]     image_width,
   output logic      [w3sf_pkg::CFG_SIZE_W-1:0]     image_height,
   output logic      [w3sf_pkg::KERNEL_W-1:0]       kernel_weights
);

   import w3sf_pkg::*;

   logic [CFG_SIZE_W-1:0]  width_ff, width_in;
   logic [CFG_SIZE_W-1:0]  height_ff, height_in;
   logic [KERNEL_W-1:0]    kernel_ff, kernel_in;
   logic [REG_INDEX_W-1:0] index;
   logic [CFG_SIZE_W-1:0]  size_value;
   logic                   write_strobe;

   assign index        = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_INDEX_W];
   assign size_value   = csr_pwdata[CFG_SIZE_W-1:0];
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      kernel_in = kernel_ff;
      if (write_strobe) begin
         unique case (index)
            REG_WIDTH: begin
               if (size_value < MIN_SIZE) begin
                  width_in = MIN_SIZE;
               end else if (32'(size_value) > MAX_WIDTH) begin
                  width_in = CFG_SIZE_W'(MAX_WIDTH);
               end else begin
                  width_in = size_value;
               end
            end
            REG_HEIGHT: begin
               if (size_value < MIN_SIZE) begin
                  height_in = MIN_SIZE;
               end else if (32'(size_value) > MAX_HEIGHT) begin
                  height_in = CFG_SIZE_W'(MAX_HEIGHT);
               end else begin
                  height_in = size_value;
               end
            end
            REG_WEIGHTS: begin
               kernel_in = csr_pwdata[KERNEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DEFAULT_SIZE;
         height_ff <= DEFAULT_SIZE;
         kernel_ff <= DEFAULT_KERNEL;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         kernel_ff <= kernel_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_WIDTH:   csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:  csr_prdata = CSR_DATA_W'(height_ff);
         REG_WEIGHTS: csr_prdata = CSR_DATA_W'(kernel_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign image_width    = width_ff;
   assign image_height   = height_ff;
   assign kernel_weights = kernel_ff;

endmodule

`default_nettype wire

### hw/rtl/w3sf_line_window.sv
`default_nettype none

module w3sf_line_window #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fetch,
   input  wire logic                            update,
   input  wire logic [w3sf_pkg::PIXEL_W-1:0]    pixel_value,
   input  wire logic                            frame_start,
   input  wire logic [w3sf_pkg::CFG_SIZE_W-1:0] image_width,
   input  wire logic [w3sf_pkg::CFG_SIZE_W-1:0] image_height,
   output w3sf_pkg::window_type                 window,
   output w3sf_pkg::position_type               position
);

   import w3sf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   pixel_type     pix_ff, pix_in;
   window_type    window_ff, window_in;

   logic [CW-1:0] width_ext;
   logic [RW-1:0] height_ext;
   logic [CW-1:0] col_start, col_fetch, col_next;
   logic [RW-1:0] row_start, row_step, row_fetch, row_next;
   logic          wrap_col;

   logic [2*PIXEL_W-1:0] line_rd_data;
   logic [2*PIXEL_W-1:0] line_wr_data;
   pixel_type            top_pixel, mid_pixel;

   assign width_ext  = CW'(image_width);
   assign height_ext = RW'(image_height);

   always_comb begin
      col_start = frame_start ? '0 : col_ff;
      row_start = frame_start ? '0 : row_ff;
      wrap_col  = col_start >= width_ext;
      col_fetch = wrap_col ? '0 : col_start;
      row_step  = wrap_col ? row_start + 1'b1 : row_start;
      row_fetch = (row_step >= height_ext) ? '0 : row_step;
   end

   assign top_pixel    = line_rd_data[2*PIXEL_W-1:PIXEL_W];
   assign mid_pixel    = line_rd_data[PIXEL_W-1:0];
   assign line_wr_data = {mid_pixel, pix_ff};

   w3sf_ram #(
      .DATA_W (2 * PIXEL_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (cur_col_ff[AW-1:0]),
      .wr_data (line_wr_data),
      .rd_en   (fetch),
      .rd_addr (col_fetch[AW-1:0]),
      .rd_data (line_rd_data)
   );

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      pix_in     = pix_ff;
      if (fetch) begin
         cur_col_in = col_fetch;
         cur_row_in = row_fetch;
         pix_in     = pixel_value;
      end
   end

   always_comb begin
      col_next = cur_col_ff + 1'b1;
      row_next = cur_row_ff + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (update) begin
         if (col_next >= width_ext) begin
            col_in = '0;
            row_in = (row_next >= height_ext) ? '0 : row_next;
         end else begin
            col_in = col_next;
            row_in = cur_row_ff;
         end
      end
   end

   always_comb begin
      window_in = window_ff;
      if (update) begin
         window_in[0] = window_ff[1];
         window_in[1] = window_ff[2];
         window_in[2] = top_pixel;
         window_in[3] = window_ff[4];
         window_in[4] = window_ff[5];
         window_in[5] = mid_pixel;
         window_in[6] = window_ff[7];
         window_in[7] = window_ff[8];
         window_in[8] = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff <= cur_col_in;
      cur_row_ff <= cur_row_in;
      pix_ff     <= pix_in;
      window_ff  <= window_in;
   end

   always_comb begin
      position.interior = (cur_row_ff >= RW'(2)) && (cur_col_ff >= CW'(2));
      position.last     = (cur_row_ff == height_ext - 1'b1) &&
                          (cur_col_ff == width_ext - 1'b1);
      position.row      = OUT_POS_W'(cur_row_ff - 1'b1);
      position.column   = OUT_POS_W'(cur_col_ff - 1'b1);
   end

   assign window = window_ff;

endmodule

`default_nettype wire

### hw/rtl/w3sf_divider.sv
`default_nettype none

module w3sf_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [w3sf_pkg::ACC_W-1:0]   dividend,
   input  wire logic [w3sf_pkg::WSUM_W-1:0]  divisor,
   output logic      [w3sf_pkg::PIXEL_W-1:0] quotient,
   output logic                              done
);

   import w3sf_pkg::*;

   localparam int CNT_W = $clog2(PIXEL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PIXEL_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WSUM_W-1:0]  rem_ff, rem_in;
   logic [PIXEL_W-1:0] low_ff, low_in;
   logic [WSUM_W-1:0]  divisor_ff, divisor_in;
   logic               zero_ff, zero_in;

   logic [WSUM_W:0]    trial;
   logic [WSUM_W:0]    diff;
   logic               fits;

   // The quotient never exceeds the pixel range, so the upper dividend bits
   // already form the first partial remainder.
   always_comb begin
      trial = {rem_ff, low_ff[PIXEL_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      divisor_in = divisor_ff;
      zero_in    = zero_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = WSUM_W'(dividend >> PIXEL_W);
         low_in     = dividend[PIXEL_W-1:0];
         divisor_in = divisor;
         zero_in    = (divisor == '0);
      end else if (busy_ff) begin
         rem_in   = fits ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
         low_in   = {low_ff[PIXEL_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      divisor_ff <= divisor_in;
      zero_ff    <= zero_in;
   end

   assign quotient = zero_ff ? '0 : low_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

### hw/rtl/weighted_3x3_smoothing_filter.sv
// Weighted 3x3 smoothing filter over a raster stream of 8-bit grey pixels.
// Requests arrive on the req_ channel (valid/ready), one pixel per request in
// raster order; req_frame_start marks row 0, column 0 of a frame. Each request
// whose window centre lies inside the image border yields one result on the
// rsp_ channel: the weighted sum of the nine neighbours divided by the weight
// sum (0 when the weights sum to zero), with the centre's row and column and a
// flag on the last interior pixel of the frame. Border requests yield nothing.
// A border request occupies the block for the line-store read and its
// write-back. An interior request then passes through the multiply, row-sum
// and sum states, the bit-serial divider (8 steps and a completion report) and
// the output state, which waits while an earlier result has not been taken.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls, a second result is held until the first
// has been taken. Image size and weights are written through the csr_ port
// between frames. Reset restores 512 x 512 and the weights 1,4,1,4,5,4,1,4,1
// and restarts position at row 0, column 0; the line stores are not cleared.
`default_nettype none

module weighted_3x3_smoothing_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [w3sf_pkg::PIXEL_W-1:0]      req_pixel_value,
   input  wire logic                              req_frame_start,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [w3sf_pkg::PIXEL_W-1:0]      rsp_filtered_value,
   output logic      [w3sf_pkg::OUT_POS_W-1:0]    rsp_center_row,
   output logic      [w3sf_pkg::OUT_POS_W-1:0]    rsp_center_column,
   output logic                                   rsp_frame_last,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [w3sf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [w3sf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [w3sf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   import w3sf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ROWS = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   logic [CFG_SIZE_W-1:0] image_width;
   logic [CFG_SIZE_W-1:0] image_height;
   logic [KERNEL_W-1:0]   kernel_weights;

   window_type   window;
   position_type position;

   logic fetch;
   logic update;
   logic div_start;
   logic div_done;
   logic load_out;

   logic [PROD_W-1:0]   prod_ff [TAPS];
   logic [PROD_W-1:0]   prod_in [TAPS];
   logic [ROWSUM_W-1:0] row_sum_ff [3];
   logic [ROWSUM_W-1:0] row_sum_in [3];
   logic [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [ACC_W-1:0]    dividend;
   logic [PIXEL_W-1:0]  quotient;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]   out_value_ff, out_value_in;
   logic [OUT_POS_W-1:0] out_row_ff, out_row_in;
   logic [OUT_POS_W-1:0] out_col_ff, out_col_in;
   logic                 out_last_ff, out_last_in;

   w3sf_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .image_width    (image_width),
      .image_height   (image_height),
      .kernel_weights (kernel_weights)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign fetch     = req_valid && req_ready;
   assign update    = (state_ff == S_READ);

   w3sf_line_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_line_window (
      .clock        (clock),
      .reset        (reset),
      .fetch        (fetch),
      .update       (update),
      .pixel_value  (req_pixel_value),
      .frame_start  (req_frame_start),
      .image_width  (image_width),
      .image_height (image_height),
      .window       (window),
      .position     (position)
   );

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = PROD_W'(kernel_weights[WEIGHT_BITS*k +: WEIGHT_BITS]) *
                      PROD_W'(window[k]);
      end
      for (int i = 0; i < 3; i++) begin
         row_sum_in[i] = ROWSUM_W'(prod_ff[3*i]) + ROWSUM_W'(prod_ff[3*i+1]) +
                         ROWSUM_W'(prod_ff[3*i+2]);
      end
      wsum_in = '0;
      for (int k = 0; k < TAPS; k++) begin
         wsum_in = wsum_in + WSUM_W'(kernel_weights[WEIGHT_BITS*k +: WEIGHT_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      row_sum_ff <= row_sum_in;
      wsum_ff    <= wsum_in;
   end

   assign dividend = ACC_W'(row_sum_ff[0]) + ACC_W'(row_sum_ff[1]) +
                     ACC_W'(row_sum_ff[2]);

   w3sf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (wsum_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = position.interior ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            state_in = S_ROWS;
         end
         S_ROWS: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_value_in = quotient;
         out_row_in   = position.row;
         out_col_in   = position.column;
         out_last_in  = position.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = out_value_ff;
   assign rsp_center_row     = out_row_ff;
   assign rsp_center_column  = out_col_ff;
   assign rsp_frame_last     = out_last_ff;

   a_done_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_out_is_interior: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> position.interior)
      else $error("result pending for a border position");

   a_read_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_READ && !req_ready)
      else $error("accepted request did not start a line-store access");

   a_centre_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_row != '0 && rsp_center_column != '0)
      else $error("result centre lies on the image border");

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import w3sf_pkg::*;

   localparam int MAX_SIDE      = 1024;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 900;
   localparam int RANDOM_FILL   = -1;

   typedef struct packed {
      logic [PIXEL_W-1:0]   value;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] column;
      logic                 last;
   } smoothed_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel_value;
   logic                  req_frame_start;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIXEL_W-1:0]    rsp_filtered_value;
   logic [OUT_POS_W-1:0]  rsp_center_row;
   logic [OUT_POS_W-1:0]  rsp_center_column;
   logic                  rsp_frame_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   smoothed_pixel_type  expected_pixels[$];
   int unsigned         mismatch_count = 0;
   int unsigned         idle_cycles = 0;
   bit                  quiet = 1'b0;

   int unsigned         frame_width;
   int unsigned         frame_height;
   logic [KERNEL_W-1:0] kernel_cfg;
   int unsigned         col_pos;
   int unsigned         row_pos;
   bit [PIXEL_W-1:0]    older_line[MAX_SIDE];
   bit [PIXEL_W-1:0]    newer_line[MAX_SIDE];
   bit [PIXEL_W-1:0]    window_px[TAPS];

   weighted_3x3_smoothing_filter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_center_row     (rsp_center_row),
      .rsp_center_column  (rsp_center_column),
      .rsp_frame_last     (rsp_frame_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp_side(input logic [CFG_SIZE_W-1:0] raw);
      if (raw < MIN_SIZE) begin
         return 32'(MIN_SIZE);
      end
      if (raw > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return 32'(raw);
   endfunction

   task automatic predict_pixel(input logic [PIXEL_W-1:0] pix, input logic start);
      int unsigned     r;
      int unsigned     c;
      int unsigned     acc;
      int unsigned     wsum;
      int unsigned     wk;
      bit [PIXEL_W-1:0] top;
      bit [PIXEL_W-1:0] mid;
      smoothed_pixel_type res;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= frame_width) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= frame_height) begin
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      top = older_line[c];
      mid = newer_line[c];
      older_line[c] = mid;
      newer_line[c] = pix;
      for (int k = 0; k < 3; k++) begin
         window_px[3*k]   = window_px[3*k+1];
         window_px[3*k+1] = window_px[3*k+2];
      end
      window_px[2] = top;
      window_px[5] = mid;
      window_px[8] = pix;
      if (r >= 2 && c >= 2) begin
         acc = 0;
         wsum = 0;
         for (int k = 0; k < TAPS; k++) begin
            wk = 32'(kernel_cfg[WEIGHT_BITS*k +: WEIGHT_BITS]);
            acc += wk * 32'(window_px[k]);
            wsum += wk;
         end
         if (wsum != 0) begin
            res.value = PIXEL_W'(acc / wsum);
         end else begin
            res.value = '0;
         end
         res.row = OUT_POS_W'(r - 1);
         res.column = OUT_POS_W'(c - 1);
         res.last = (r == frame_height - 1) && (c == frame_width - 1);
         expected_pixels.push_back(res);
      end
      col_pos = c + 1;
      if (col_pos >= frame_width) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= frame_height) begin
            row_pos = 0;
         end
      end
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic start);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(pix, start);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      release_request();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [REG_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_WIDTH: begin
            frame_width = clamp_side(value[CFG_SIZE_W-1:0]);
         end
         REG_HEIGHT: begin
            frame_height = clamp_side(value[CFG_SIZE_W-1:0]);
         end
         REG_WEIGHTS: begin
            kernel_cfg = value[KERNEL_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [CFG_SIZE_W-1:0] width_raw,
                            input logic [CFG_SIZE_W-1:0] height_raw,
                            input logic [KERNEL_W-1:0] kernel);
      wait_idle();
      write_register(REG_WIDTH, CSR_DATA_W'(width_raw));
      write_register(REG_HEIGHT, CSR_DATA_W'(height_raw));
      write_register(REG_WEIGHTS, CSR_DATA_W'(kernel));
   endtask

   task automatic send_pixels(input int unsigned count, input bit first_start,
                              input int fill, input bit noisy);
      logic [PIXEL_W-1:0] pix;
      logic               start;
      for (int unsigned i = 0; i < count; i++) begin
         if (fill >= 0) begin
            pix = PIXEL_W'(fill);
         end else begin
            case ($urandom_range(0, 9))
               0: pix = '0;
               1: pix = PIXEL_W'(PIXEL_MAX);
               default: pix = PIXEL_W'($urandom_range(0, PIXEL_MAX));
            endcase
         end
         start = (i == 0 && first_start) || (noisy && $urandom_range(0, 39) == 0);
         send_pixel(pix, start);
      end
   endtask

   function automatic logic [KERNEL_W-1:0] random_kernel();
      return KERNEL_W'({$urandom, $urandom});
   endfunction

   task automatic test_reset_defaults();
      send_pixels(24, 1'b1, RANDOM_FILL, 1'b0);
      wait_idle();
      write_register(REG_WIDTH, CSR_DATA_W'(6));
      write_register(REG_HEIGHT, CSR_DATA_W'(4));
      send_pixels(24, 1'b1, RANDOM_FILL, 1'b0);
   endtask

   task automatic test_extreme_pixels();
      configure(11'd3, 11'd3, '1);
      send_pixels(9, 1'b1, PIXEL_MAX, 1'b0);
      send_pixels(9, 1'b1, 0, 1'b0);
   endtask

   task automatic test_zero_weights();
      configure(11'd3, 11'd3, '0);
      send_pixels(9, 1'b1, RANDOM_FILL, 1'b0);
   endtask

   task automatic test_shrink_wrap();
      logic [KERNEL_W-1:0] kernel;
      kernel = random_kernel();
      configure(11'd6, 11'd6, kernel);
      send_pixels(17, 1'b1, RANDOM_FILL, 1'b0);
      configure(11'd3, 11'd3, kernel);
      send_pixels(9, 1'b0, RANDOM_FILL, 1'b0);
   endtask

   task automatic test_largest_sizes();
      configure(11'd3, 11'd2047, random_kernel());
      send_pixels(60, 1'b1, RANDOM_FILL, 1'b0);
      configure(11'd2047, 11'd3, random_kernel());
      send_pixels(24, 1'b1, RANDOM_FILL, 1'b0);
   endtask

   task automatic test_random_frames();
      int unsigned         sent;
      int unsigned         count;
      int unsigned         frames;
      logic [CFG_SIZE_W-1:0] width_raw;
      logic [CFG_SIZE_W-1:0] height_raw;
      logic [KERNEL_W-1:0] kernel;
      bit                  noisy;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= RANDOM_ITEMS * 17 / 20);
         if ($urandom_range(0, 4) == 0) begin
            width_raw = CFG_SIZE_W'($urandom_range(3, 64));
            height_raw = CFG_SIZE_W'($urandom_range(3, 5));
         end else begin
            width_raw = CFG_SIZE_W'($urandom_range(3, 12));
            height_raw = CFG_SIZE_W'($urandom_range(3, 8));
         end
         if ($urandom_range(0, 9) == 0) begin
            width_raw = CFG_SIZE_W'($urandom_range(0, 2));
         end
         if ($urandom_range(0, 9) == 0) begin
            height_raw = CFG_SIZE_W'($urandom_range(0, 2));
         end
         case ($urandom_range(0, 11))
            0: kernel = '0;
            1: kernel = '1;
            2: kernel = DEFAULT_KERNEL;
            default: kernel = random_kernel();
         endcase
         configure(width_raw, height_raw, kernel);
         frames = $urandom_range(1, 2);
         for (int unsigned f = 0; f < frames; f++) begin
            noisy = ($urandom_range(0, 4) == 0);
            count = clamp_side(width_raw) * clamp_side(height_raw);
            if ($urandom_range(0, 7) == 0) begin
               count = $urandom_range(1, count - 1);
            end
            send_pixels(count, f == 0, RANDOM_FILL, noisy);
            sent += count;
         end
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      smoothed_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: value %0d row %0d column %0d last %0b",
                        rsp_filtered_value, rsp_center_row, rsp_center_column,
                        rsp_frame_last);
            end
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_filtered_value !== want.value || rsp_center_row !== want.row ||
                rsp_center_column !== want.column || rsp_frame_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                           want.value, want.row, want.column, want.last,
                           rsp_filtered_value, rsp_center_row, rsp_center_column,
                           rsp_frame_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_value = '0;
      req_frame_start = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      frame_width = 32'(DEFAULT_SIZE);
      frame_height = 32'(DEFAULT_SIZE);
      kernel_cfg = DEFAULT_KERNEL;
      col_pos = 0;
      row_pos = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extreme_pixels();
      test_zero_weights();
      test_shrink_wrap();
      test_largest_sizes();
      test_random_frames();
      wait_idle();
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

### weighted_3x3_smoothing_filter.f
hw/rtl/w3sf_pkg.sv
hw/rtl/w3sf_ram.sv
hw/rtl/w3sf_csr.sv
hw/rtl/w3sf_line_window.sv
hw/rtl/w3sf_divider.sv
hw/rtl/weighted_3x3_smoothing_filter.sv
verif/tb_top.sv
